// ===== sv/dpo_pkg.sv =====
// Shared types and constants for the deadband path-length odometer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dpo_pkg;

	// Field widths
	localparam int POS_BITS   = 24;
	localparam int TOTAL_BITS = 32;
	localparam int MODE_BITS  = 2;
	localparam int THR_BITS   = 16;

	// Derived datapath widths
	localparam int SQ_BITS   = 2 * POS_BITS;
	localparam int SUM_BITS  = SQ_BITS + 2;
	localparam int ROOT_BITS = SUM_BITS / 2;
	localparam int CNT_BITS  = $clog2(ROOT_BITS);
	localparam int ACC_BITS  = ((TOTAL_BITS > ROOT_BITS) ? TOTAL_BITS : ROOT_BITS) + 1;
	localparam int CMP_BITS  = (ROOT_BITS > THR_BITS) ? ROOT_BITS : THR_BITS;

	// Queue between front and back (depth a power of two)
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

	// Configuration port
	localparam int                PADDR_BITS = 3;
	localparam int                PDATA_BITS = 32;
	localparam logic              REG_THRESHOLD = 1'b0;
	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(10);

	// Input mode codes
	localparam logic [MODE_BITS-1:0] MODE_POSE    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_RELOC   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PUBLISH = 2'd2;

	typedef enum logic [1:0] {
		K_POSE,
		K_RELOC,
		K_PUBLISH
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic signed [POS_BITS-1:0]  x;
		logic signed [POS_BITS-1:0]  y;
		logic signed [POS_BITS-1:0]  z;
	} item_t;

	typedef struct packed {
		logic                 done;
		logic [ROOT_BITS-1:0] root;
	} sqrt_res_t;

endpackage

`default_nettype wire

// ===== sv/dpo_front.sv =====
// Front end: accepts input items, classifies the mode and queues them.
// Depends on dpo_pkg.
`default_nettype none

module dpo_front import dpo_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [MODE_BITS-1:0]       mode,
	input  wire logic signed [POS_BITS-1:0] pos_x,
	input  wire logic signed [POS_BITS-1:0] pos_y,
	input  wire logic signed [POS_BITS-1:0] pos_z,
	output logic                            q_valid,
	output item_t                           q_item,
	input  wire logic                       q_pop
);

	item_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_PTR_BITS:0]   count_q;
	item_t                 cls_item;
	logic                  cls_keep;
	logic                  push;

	// Classify; drop the unused mode right here
	always_comb begin
		cls_item.x    = pos_x;
		cls_item.y    = pos_y;
		cls_item.z    = pos_z;
		cls_item.kind = K_POSE;
		cls_keep      = 1'b1;
		case (mode)
			MODE_POSE:    cls_item.kind = K_POSE;
			MODE_RELOC:   cls_item.kind = K_RELOC;
			MODE_PUBLISH: cls_item.kind = K_PUBLISH;
			default:      cls_keep = 1'b0;
		endcase
	end

	assign in_ready = (count_q != (Q_PTR_BITS+1)'(Q_DEPTH));
	assign push     = in_valid && in_ready && cls_keep;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/dpo_isqrt.sv =====
// Iterative integer square root (floor), one result bit per cycle.
// Depends on dpo_pkg.
`default_nettype none

module dpo_isqrt import dpo_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_BITS-1:0] operand,
	output sqrt_res_t                res
);

	logic [SUM_BITS-1:0]    n_q;
	logic [ROOT_BITS+1:0]   r_q;
	logic [ROOT_BITS-1:0]   q_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [ROOT_BITS+1:0]   r_shift;
	logic [ROOT_BITS+1:0]   trial;
	logic                   fits;

	// Bring down the next two bits and try a one in the next root position
	assign r_shift = {r_q[ROOT_BITS-1:0], n_q[SUM_BITS-1 -: 2]};
	assign trial   = {q_q, 2'b01};
	assign fits    = (r_shift >= trial);

	assign res.done = done_q;
	assign res.root = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= operand;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[SUM_BITS-3:0], 2'b00};
			r_q <= fits ? (r_shift - trial) : r_shift;
			q_q <= {q_q[ROOT_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/dpo_back.sv =====
// Back end: executes queued items, measures steps and keeps the total.
// Depends on dpo_pkg and dpo_isqrt.
`default_nettype none

module dpo_back import dpo_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire item_t                 q_item,
	output logic                       q_pop,
	input  wire logic [THR_BITS-1:0]   thr,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TOTAL_BITS-1:0]      travelled_mm
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ROOT
	} state_t;

	state_t                    state_q;
	logic                      started_q;
	logic                      pending_q;
	logic signed [POS_BITS-1:0] ref_x_q;
	logic signed [POS_BITS-1:0] ref_y_q;
	logic signed [POS_BITS-1:0] ref_z_q;
	logic [TOTAL_BITS-1:0]     total_q;
	logic                      out_valid_q;
	logic [TOTAL_BITS-1:0]     travelled_q;
	item_t                     new_s1;
	logic [POS_BITS-1:0]       dx_s1;
	logic [POS_BITS-1:0]       dy_s1;
	logic [POS_BITS-1:0]       dz_s1;
	logic [SQ_BITS-1:0]        sqx_s2;
	logic [SQ_BITS-1:0]        sqy_s2;
	logic [SQ_BITS-1:0]        sqz_s2;
	logic                      out_free;
	logic                      sq_start;
	logic [SUM_BITS-1:0]       sq_operand;
	sqrt_res_t                 sq_res;
	logic [ACC_BITS-1:0]       acc_sum;
	logic                      step_moves;

	function automatic logic [POS_BITS-1:0] abs_diff(
		input logic signed [POS_BITS-1:0] a,
		input logic signed [POS_BITS-1:0] b
	);
		logic signed [POS_BITS:0] d;
		d = {a[POS_BITS-1], a} - {b[POS_BITS-1], b};
		if (d[POS_BITS]) begin
			d = -d;
		end
		return d[POS_BITS-1:0];
	endfunction

	dpo_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_operand),
		.res     (sq_res)
	);

	assign out_free   = !out_valid_q || out_ready;
	assign q_pop      = (state_q == ST_IDLE) && q_valid &&
	                    ((q_item.kind != K_PUBLISH) || !started_q || out_free);
	assign sq_start   = (state_q == ST_SUM);
	assign sq_operand = SUM_BITS'(sqx_s2) + SUM_BITS'(sqy_s2) + SUM_BITS'(sqz_s2);
	assign acc_sum    = ACC_BITS'(total_q) + ACC_BITS'(sq_res.root);
	assign step_moves = (CMP_BITS'(sq_res.root) > CMP_BITS'(thr));

	assign out_valid    = out_valid_q;
	assign travelled_mm = travelled_q;

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.kind == K_POSE)) begin
			new_s1 <= q_item;
			dx_s1  <= abs_diff(q_item.x, ref_x_q);
			dy_s1  <= abs_diff(q_item.y, ref_y_q);
			dz_s1  <= abs_diff(q_item.z, ref_z_q);
		end
		if (state_q == ST_MUL) begin
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			sqz_s2 <= dz_s1 * dz_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			pending_q   <= 1'b0;
			ref_x_q     <= '0;
			ref_y_q     <= '0;
			ref_z_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			travelled_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.kind)
							K_RELOC: begin
								pending_q <= 1'b1;
								ref_x_q   <= q_item.x;
								ref_y_q   <= q_item.y;
								ref_z_q   <= q_item.z;
							end
							K_PUBLISH: begin
								if (started_q) begin
									out_valid_q <= 1'b1;
									travelled_q <= total_q;
									total_q     <= '0;
								end
							end
							K_POSE: begin
								if (!started_q || pending_q) begin
									// Take the pose as the new reference
									if (started_q) begin
										pending_q <= 1'b0;
									end
									started_q <= 1'b1;
									ref_x_q   <= q_item.x;
									ref_y_q   <= q_item.y;
									ref_z_q   <= q_item.z;
								end else begin
									state_q <= ST_MUL;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sq_res.done) begin
						state_q <= ST_IDLE;
						if (step_moves) begin
							total_q <= (acc_sum[ACC_BITS-1:TOTAL_BITS] != '0) ?
							           '1 : acc_sum[TOTAL_BITS-1:0];
							ref_x_q <= new_s1.x;
							ref_y_q <= new_s1.y;
							ref_z_q <= new_s1.z;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> started_q && !pending_q)
		else $error("step measured before a reference was set");

	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_res.done |-> (state_q == ST_ROOT))
		else $error("square root finished outside its wait state");

	a_publish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q_item.kind == K_PUBLISH) && started_q) |-> out_free)
		else $error("publish popped while the output register is full");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ROOT) && !sq_res.done) |=> $stable(total_q))
		else $error("total changed while a step was being measured");

endmodule

`default_nettype wire

// ===== sv/deadband_path_length_odometer_core.sv =====
// Top level of the deadband path-length odometer: APB register, front, back.
// Depends on dpo_pkg, dpo_front and dpo_back.
`default_nettype none

// Path-length odometer with a motion deadband. Each input item carries a mode
// (pose, relocalize with pose, publish tick) and a signed 3-D position in mm.
// The first pose, and the first pose after a relocalize, only set the
// reference point. Later poses measure floor(sqrt(dx^2+dy^2+dz^2)) to the
// reference; a step strictly above step_threshold_mm (APB byte address 0,
// reset 10) is added to a saturating 32-bit total and moves the reference.
// A publish tick, once a first pose has been seen, returns the total as one
// result item and clears it; every other item returns nothing. Mode 3 is
// accepted and dropped. The front accepts an item per cycle into a
// two-entry queue while it has room. The back handles a relocalize, a
// publish or a reference-setting pose without leaving its idle state. A
// pose that measures a step goes through abs difference, multiply, sum and
// the bit-serial square root (one iteration per root bit, then hand-back),
// which sets the sustained rate; no new item is popped until it is done. A
// publish waits in the queue while the previous result has not been taken.
module deadband_path_length_odometer_core import dpo_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [PADDR_BITS-1:0]      paddr,
	input  wire logic [PDATA_BITS-1:0]      pwdata,
	output logic [PDATA_BITS-1:0]           prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [MODE_BITS-1:0]       mode,
	input  wire logic signed [POS_BITS-1:0] pos_x,
	input  wire logic signed [POS_BITS-1:0] pos_y,
	input  wire logic signed [POS_BITS-1:0] pos_z,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [TOTAL_BITS-1:0]           travelled_mm
);

	logic [THR_BITS-1:0] thr_q;
	logic                q_valid;
	item_t               q_item;
	logic                q_pop;
	logic                reg_idx;

	// Word index of the register; bit 2 selects the slot past the list
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = PDATA_BITS'(thr_q);
			default:       prdata = '0;
		endcase
	end

	// Write the threshold on the access phase; ignore other addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_THRESHOLD)) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	// Accept and classify items, hold them in the queue
	dpo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Execute queued items and drive the result register
	dpo_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.thr          (thr_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.travelled_mm (travelled_mm)
	);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for deadband_path_length_odometer_core: a directed pose table, then random walks.
// Results are checked against a predictor kept in this file. Depends on dpo_pkg and the core.

module tb;
	import dpo_pkg::*;

	// Mode 3 is not defined by the block; it must be swallowed without a result
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

	// Register map: one 32-bit register per word, so register i sits at byte 4*i
	localparam logic [PADDR_BITS-1:0] ADDR_THRESHOLD = PADDR_BITS'(4 * REG_THRESHOLD);
	localparam logic [PADDR_BITS-1:0] ADDR_UNMAPPED  = PADDR_BITS'(4 * (REG_THRESHOLD + 1));

	localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
	localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
	localparam logic [TOTAL_BITS-1:0]      TOTAL_SAT = '1;

	// Two queued items and one in the back can still be in flight after the
	// last result; the drain wait covers them with margin.
	localparam int DRAIN_CYCLES = 120;
	// Slowest run: ~900 items with gaps, busy measurements and stalls, plus the
	// drains and the long hold-off, stays well inside this limit.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_AFTER   = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int HAUL_LAPS    = 160;
	localparam int DIR_ROWS     = 25;

	// Where the expected total of a row comes from
	typedef enum bit {FROM_PREDICTOR, TYPED} exp_src_e;

	typedef struct packed {
		logic [MODE_BITS-1:0]       mode;
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic signed [POS_BITS-1:0] z;
		exp_src_e                   src;
		logic [TOTAL_BITS-1:0]      total;
	} pose_row_t;

	// Directed table, threshold at its reset value of 10. Totals are typed in
	// only where they are obvious; the rest come from the predictor.
	pose_row_t dir_rows [DIR_ROWS] = '{
		// publish before the first pose: nothing comes out
		'{MODE_PUBLISH, 1, 2, 3, FROM_PREDICTOR, 32'd0},
		// undefined mode before start: dropped
		'{MODE_UNUSED, 7, 7, 7, FROM_PREDICTOR, 32'd0},
		// relocalize before start: reference set, pending raised
		'{MODE_RELOC, 100, 0, 0, FROM_PREDICTOR, 32'd0},
		// first pose: starts, pending stays raised
		'{MODE_POSE, 0, 0, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_PUBLISH, 0, 0, 0, TYPED, 32'd0},
		// pose while pending: clears pending and only moves the reference
		'{MODE_POSE, 5, 0, 0, FROM_PREDICTOR, 32'd0},
		// step equal to the threshold: ignored
		'{MODE_POSE, 5, 10, 0, FROM_PREDICTOR, 32'd0},
		// one above: counted
		'{MODE_POSE, 5, 11, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_POSE, 5, 11, 11, FROM_PREDICTOR, 32'd0},
		// pose fields of a publish are don't-care
		'{MODE_PUBLISH, -1, -1, -1, TYPED, 32'd22},
		'{MODE_PUBLISH, 0, 0, 0, TYPED, 32'd0},
		// 3-4-5 step below the deadband
		'{MODE_POSE, 8, 15, 11, FROM_PREDICTOR, 32'd0},
		// corner to corner: widest differences and the largest root
		'{MODE_POSE, POS_MIN, POS_MIN, POS_MIN, FROM_PREDICTOR, 32'd0},
		'{MODE_POSE, POS_MAX, POS_MAX, POS_MAX, FROM_PREDICTOR, 32'd0},
		'{MODE_POSE, POS_MAX, POS_MIN, POS_MAX, FROM_PREDICTOR, 32'd0},
		'{MODE_PUBLISH, POS_MAX, POS_MIN, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_RELOC, POS_MIN, POS_MAX, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_UNUSED, -1, -1, -1, FROM_PREDICTOR, 32'd0},
		// pose after relocalize while started: clears pending, adds nothing
		'{MODE_POSE, 0, 0, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_POSE, 0, 0, 13, FROM_PREDICTOR, 32'd0},
		// relocalize leaves the total alone
		'{MODE_RELOC, 0, 0, 1000, FROM_PREDICTOR, 32'd0},
		'{MODE_PUBLISH, 0, 0, 0, TYPED, 32'd13},
		'{MODE_POSE, 0, 0, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_POSE, 12, 0, 0, FROM_PREDICTOR, 32'd0},
		'{MODE_PUBLISH, 0, 0, 0, TYPED, 32'd12}
	};

	logic                       clk;
	logic                       arst_n  = 1'b0;
	logic                       psel    = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite  = 1'b0;
	logic [PADDR_BITS-1:0]      paddr   = '0;
	logic [PDATA_BITS-1:0]      pwdata  = '0;
	logic [PDATA_BITS-1:0]      prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [MODE_BITS-1:0]       mode  = MODE_POSE;
	logic signed [POS_BITS-1:0] pos_x = '0;
	logic signed [POS_BITS-1:0] pos_y = '0;
	logic signed [POS_BITS-1:0] pos_z = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [TOTAL_BITS-1:0]      travelled_mm;

	// Predictor state, mirroring the block after reset
	logic [THR_BITS-1:0]        thr_cfg = THR_RESET;
	bit                         odo_started   = 1'b0;
	bit                         reloc_pending = 1'b0;
	logic signed [POS_BITS-1:0] anchor_x = '0;
	logic signed [POS_BITS-1:0] anchor_y = '0;
	logic signed [POS_BITS-1:0] anchor_z = '0;
	logic [TOTAL_BITS-1:0]      travelled_acc = '0;

	// Totals still owed by the block, oldest first
	logic [TOTAL_BITS-1:0]      pending_totals [$];

	int                         mismatches = 0;
	int                         cycles = 0;
	// When set, both sides run back to back with no idle cycles
	bit                         steady = 1'b0;
	// Current point of the random walk
	logic signed [POS_BITS-1:0] walk_x = '0;
	logic signed [POS_BITS-1:0] walk_y = '0;
	logic signed [POS_BITS-1:0] walk_z = '0;

	deadband_path_length_odometer_core DUT (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.in_valid,
		.in_ready,
		.mode,
		.pos_x,
		.pos_y,
		.pos_z,
		.out_valid,
		.out_ready,
		.travelled_mm
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("deadband_path_length_odometer_core verification failed");
			$finish;
		end
	end

	// Floor of the square root, built bit by bit from the top
	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned axis_gap(input logic signed [POS_BITS-1:0] a,
	                                             input logic signed [POS_BITS-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	// Advance the odometer by one accepted item; return 1 when it emits a total
	function automatic bit odo_advance(input pose_row_t r, output logic [TOTAL_BITS-1:0] mm);
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned dz;
		longint unsigned stride;
		longint unsigned sum;
		bit              emits;
		emits = 1'b0;
		mm = '0;
		case (r.mode)
			MODE_RELOC: begin
				reloc_pending = 1'b1;
				anchor_x = r.x;
				anchor_y = r.y;
				anchor_z = r.z;
			end
			MODE_PUBLISH: begin
				if (odo_started) begin
					mm = travelled_acc;
					travelled_acc = '0;
					emits = 1'b1;
				end
			end
			MODE_POSE: begin
				if (!odo_started || reloc_pending) begin
					// Reference-setting pose; a pending relocalize survives the very first one
					if (odo_started)
						reloc_pending = 1'b0;
					odo_started = 1'b1;
					anchor_x = r.x;
					anchor_y = r.y;
					anchor_z = r.z;
				end else begin
					dx = axis_gap(r.x, anchor_x);
					dy = axis_gap(r.y, anchor_y);
					dz = axis_gap(r.z, anchor_z);
					stride = floor_root(dx * dx + dy * dy + dz * dz);
					// Deadband: the step must be strictly above the threshold
					if (stride > thr_cfg) begin
						sum = travelled_acc + stride;
						travelled_acc = (sum > TOTAL_SAT) ? TOTAL_SAT : sum[TOTAL_BITS-1:0];
						anchor_x = r.x;
						anchor_y = r.y;
						anchor_z = r.z;
					end
				end
			end
			default: ;
		endcase
		return emits;
	endfunction

	// Offer one item after a random gap and hold it until accepted. Valid is
	// lowered only when a gap follows, so it never toggles within one step.
	task automatic drive_item(input pose_row_t r);
		int                    gap;
		logic [TOTAL_BITS-1:0] mm;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		pos_x <= r.x;
		pos_y <= r.y;
		pos_z <= r.z;
		do @(posedge clk); while (!in_ready);
		if (odo_advance(r, mm))
			pending_totals.push_back((r.src == TYPED) ? r.total : mm);
	endtask

	// Drop valid, wait for every owed total, then let the back finish any
	// pose that is still being measured.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register over APB, then read the threshold back. psel is lowered
	// after each transfer, which keeps psel from toggling within one step.
	task automatic program_reg(input logic [PADDR_BITS-1:0] addr,
	                           input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		// Writes to unmapped addresses are dropped by the block
		if (addr == ADDR_THRESHOLD)
			thr_cfg = data[THR_BITS-1:0];
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= ADDR_THRESHOLD;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== PDATA_BITS'(thr_cfg)) begin
			$error("prdata: expected %0d, got %0d", thr_cfg, prdata);
			mismatches++;
		end
		@(posedge clk);
	endtask

	function automatic int jitter(input int s);
		return int'($urandom_range(0, 2 * s)) - s;
	endfunction

	// Random items: mostly a pose walk whose steps straddle the threshold,
	// with relocalizes, publishes, big jumps, full-range poses and mode 3 noise.
	task automatic run_random(input int count);
		pose_row_t r;
		int        pick;
		int        span;
		int        reach;
		for (int i = 0; i < count; i++) begin
			// Flip between idling and back-to-back stretches
			if (i % 40 == 0)
				steady = ($urandom_range(0, 4) == 0);
			span = (thr_cfg < 4) ? 4 : int'(thr_cfg);
			pick = $urandom_range(0, 99);
			r.src = FROM_PREDICTOR;
			r.total = '0;
			r.x = POS_BITS'($urandom);
			r.y = POS_BITS'($urandom);
			r.z = POS_BITS'($urandom);
			if (pick < 8) begin
				r.mode = MODE_RELOC;
				// Mostly relocalize onto the walk, sometimes somewhere random
				if (pick < 5) begin
					r.x = walk_x;
					r.y = walk_y;
					r.z = walk_z;
				end
				walk_x = r.x;
				walk_y = r.y;
				walk_z = r.z;
			end else if (pick < 22) begin
				r.mode = MODE_PUBLISH;
			end else if (pick < 25) begin
				r.mode = MODE_UNUSED;
			end else begin
				r.mode = MODE_POSE;
				if (pick >= 30) begin
					reach = (pick < 36) ? span * 64 : span;
					walk_x = walk_x + POS_BITS'(jitter(reach));
					walk_y = walk_y + POS_BITS'(jitter(reach));
					walk_z = walk_z + POS_BITS'(jitter(reach));
				end else begin
					walk_x = r.x;
					walk_y = r.y;
					walk_z = r.z;
				end
				r.x = walk_x;
				r.y = walk_y;
				r.z = walk_z;
			end
			drive_item(r);
		end
	endtask

	// Bounce between opposite corners until the total pins at its maximum,
	// then publish it.
	task automatic run_haul(input int laps);
		pose_row_t r;
		r.src = FROM_PREDICTOR;
		r.total = '0;
		r.mode = MODE_POSE;
		for (int i = 0; i <= laps; i++) begin
			r.x = (i % 2 == 1) ? POS_MAX : POS_MIN;
			r.y = r.x;
			r.z = r.x;
			drive_item(r);
		end
		r.mode = MODE_PUBLISH;
		drive_item(r);
	endtask

	// Result side: random stall before each item, plus one long hold-off after
	// a few results so that a publish backs up and the input queue fills.
	initial begin : result_sink
		int w;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			w = steady ? 0 : $urandom_range(0, 7);
			if (taken == HOLD_AFTER)
				w = HOLD_CYCLES;
			if (w != 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Compare every accepted total with the oldest one owed
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_totals.size() == 0) begin
				$error("travelled_mm: expected no item, got %0d", travelled_mm);
				mismatches++;
			end else begin
				if (travelled_mm !== pending_totals[0]) begin
					$error("travelled_mm: expected %0d, got %0d", pending_totals[0], travelled_mm);
					mismatches++;
				end
				pending_totals.delete(0);
			end
		end
	end

	initial begin : stimulus
		// Hold reset low, then release it once
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			drive_item(dir_rows[i]);
		settle();

		// Unmapped write must leave the threshold at its reset value
		program_reg(ADDR_UNMAPPED, 32'd3);
		run_random(200);
		settle();

		// Zero threshold: any nonzero step counts
		program_reg(ADDR_THRESHOLD, 32'd0);
		run_random(200);
		settle();

		// Widest deadband, then drive the total into saturation
		program_reg(ADDR_THRESHOLD, 32'd65535);
		run_random(200);
		run_haul(HAUL_LAPS);
		settle();

		program_reg(ADDR_THRESHOLD, PDATA_BITS'($urandom_range(0, 65535)));
		run_random(120);
		settle();

		if (mismatches == 0)
			$display("deadband_path_length_odometer_core verification clean");
		else
			$display("deadband_path_length_odometer_core verification failed");
		$finish;
	end

endmodule
